@@ hw/rtl/rgq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgq_pkg
// Shared types and constants of the ratio graph query engine.
// ----------------------------------------------------------------------------
package rgq_pkg;

  localparam logic [31:0] Q_ONE = 32'h0001_0000;
  localparam logic [31:0] Q_MAX = 32'hFFFF_FFFF;

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_ZERO = 2'd2;
  localparam logic [1:0] ST_SAT  = 2'd3;

  typedef enum logic [2:0] {
    RS_NONE, RS_ZERO, RS_FULL, RS_ADD, RS_HIT, RS_OVF
  } res_sel_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_REG_A, S_REG_B, S_ROOM, S_DIV, S_WR_AB, S_WR_BA,
    S_Q_INIT, S_POP, S_POP_TAKE, S_EDGE_RD, S_EDGE_WAIT, S_EVAL, S_DONE
  } state_t;

  typedef struct packed {
    logic     load;
    logic     reg_a;
    logic     reg_b;
    logic     div_start;
    logic     wr_ab;
    logic     wr_ba;
    logic     q_init;
    logic     pop;
    logic     pop_take;
    logic     edge_mul;
    logic     push;
    logic     idx_inc;
    logic     res_load;
    res_sel_t res_sel;
  } cmd_t;

  typedef struct packed {
    logic op;
    logic r_zero;
    logic known_ab;
    logic room;
    logic div_done;
    logic sp_zero;
    logic edge_end;
    logic hit;
    logic e_visited;
    logic stack_full;
  } sts_t;

endpackage

@@ hw/rtl/ratio_graph_query_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ratio_graph_query_engine
// Ratio graph: add a/b=r equations, answer a/b queries by depth-first walk.
// ----------------------------------------------------------------------------
// One transaction in gives one transaction out. An add spends most of its time
// in the wait on the 33-step serial divider that forms the reciprocal ratio. In
// a query, each edge read from the neighbour memory is followed by a product
// register and a compare step. A new transaction is taken while the previous
// result still waits on the output.
module ratio_graph_query_engine
  import rgq_pkg::*;
#(
  parameter int NODE_COUNT  = 64,
  parameter int MAX_DEGREE  = 16,
  parameter int STACK_DEPTH = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,  // opcode, node_a[5:0], node_b[5:0], ratio_in[31:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata   // ratio_out[31:0], found, status[1:0]
);

  cmd_t cmd;
  sts_t sts;

  rgq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rgq_datapath #(
    .NODE_COUNT  (NODE_COUNT),
    .MAX_DEGREE  (MAX_DEGREE),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_datapath (
    .clk     (clk),
    .rst     (rst),
    .s_tdata (s_tdata),
    .cmd     (cmd),
    .sts     (sts),
    .m_tdata (m_tdata)
  );

endmodule

@@ hw/rtl/rgq_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgq_datapath
// Node tables, edge memory, walk stack, divider, multiplier and result register.
// ----------------------------------------------------------------------------
module rgq_datapath
  import rgq_pkg::*;
#(
  parameter int NODE_COUNT  = 64,
  parameter int MAX_DEGREE  = 16,
  parameter int STACK_DEPTH = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [47:0] s_tdata,
  input  cmd_t        cmd,
  output sts_t        sts,
  output logic [39:0] m_tdata
);

  localparam int NW  = $clog2(NODE_COUNT);
  localparam int CW  = $clog2(MAX_DEGREE + 1);
  localparam int TAW = $clog2(NODE_COUNT * MAX_DEGREE);
  localparam int SPW = $clog2(STACK_DEPTH + 1);
  localparam int SAW = $clog2(STACK_DEPTH);
  localparam int EW  = NW + 32;
  localparam int FW  = NW + 33;

  logic          op;
  logic [NW-1:0] a, b;
  logic [31:0]   r;

  logic [NODE_COUNT-1:0] known;
  logic [NODE_COUNT-1:0] visited;

  // neighbour counts; an entry is only meaningful once its node is known
  logic [CW-1:0] cnt_mem [NODE_COUNT];
  logic [CW-1:0] cnt_rd;
  logic          cnt_we;
  logic [NW-1:0] cnt_waddr, cnt_raddr;
  logic [CW-1:0] cnt_wdata;
  logic [CW-1:0] cnt_a, cnt_b;

  logic [EW-1:0] tbl [NODE_COUNT * MAX_DEGREE];
  logic [EW-1:0] tbl_rd;
  logic [FW-1:0] stk [STACK_DEPTH];
  logic [FW-1:0] stk_rd;
  logic [SPW-1:0] sp;

  logic [32:0] dv_rem, dv_sh;
  logic [5:0]  dv_cnt;
  logic [32:0] dv_trial;

  logic [NW-1:0] cur_node, e_node;
  logic [31:0]   cur_prod;
  logic          cur_sat;
  logic [CW-1:0] idx;
  logic [63:0]   prod;
  logic [64:0]   prod_rnd;
  logic [31:0]   pval;
  logic          psat;

  logic [31:0] res_ratio;
  logic        res_found;
  logic [1:0]  res_status;

  logic           tbl_we;
  logic [TAW-1:0] tbl_waddr, tbl_raddr;
  logic [EW-1:0]  tbl_wdata;
  logic [CW:0]    cnt_a2;

  always_comb begin
    tbl_we    = 1'b0;
    tbl_waddr = TAW'(a * MAX_DEGREE);
    tbl_wdata = {a, Q_ONE};
    if (cmd.reg_b) begin
      tbl_we    = 1'b1;
      tbl_waddr = TAW'(b * MAX_DEGREE);
      tbl_wdata = {b, Q_ONE};
    end else if (cmd.reg_a) begin
      tbl_we = 1'b1;
    end else if (cmd.wr_ab) begin
      tbl_we    = 1'b1;
      tbl_waddr = TAW'(a * MAX_DEGREE + cnt_a);
      tbl_wdata = {b, r};
    end else if (cmd.wr_ba) begin
      tbl_we    = 1'b1;
      tbl_waddr = TAW'(b * MAX_DEGREE + cnt_b);
      tbl_wdata = {a, (dv_sh[32] ? Q_MAX : dv_sh[31:0])};
    end
  end

  assign tbl_raddr = TAW'(cur_node * MAX_DEGREE + idx);

  always_ff @(posedge clk) begin
    if (tbl_we) tbl[tbl_waddr] <= tbl_wdata;
    tbl_rd <= tbl[tbl_raddr];
  end

  // count memory: read a then b during an add, the popped node during a query
  always_comb begin
    cnt_we    = 1'b0;
    cnt_waddr = a;
    cnt_wdata = CW'(1);
    if (cmd.reg_a) begin
      cnt_we = !known[a];
    end else if (cmd.reg_b) begin
      cnt_we    = !known[b];
      cnt_waddr = b;
    end else if (cmd.wr_ab) begin
      cnt_we    = 1'b1;
      cnt_wdata = cnt_a + 1'b1;
    end else if (cmd.wr_ba) begin
      cnt_we    = 1'b1;
      cnt_waddr = b;
      cnt_wdata = cnt_b + 1'b1;
    end
  end

  assign cnt_raddr = (op == OP_QUERY) ? stk_rd[FW-1:33] : (cmd.reg_a ? b : a);

  always_ff @(posedge clk) begin
    if (cnt_we) cnt_mem[cnt_waddr] <= cnt_wdata;
    cnt_rd <= cnt_mem[cnt_raddr];
  end

  // walk stack: seed on query start, push on unvisited neighbour
  always_ff @(posedge clk) begin
    if (cmd.q_init) stk[0] <= {a, Q_ONE, 1'b0};
    else if (cmd.push) stk[sp[SAW-1:0]] <= {e_node, pval, psat};
    if (cmd.pop) stk_rd <= stk[SAW'(sp - 1'b1)];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op <= s_tdata[0];
      a  <= NW'(s_tdata[6:1] % NODE_COUNT);
      b  <= NW'(s_tdata[12:7] % NODE_COUNT);
      r  <= s_tdata[44:13];
    end
    if (cmd.reg_a) cnt_a <= known[a] ? cnt_rd : CW'(1);
    else if (cmd.wr_ab) cnt_a <= cnt_a + 1'b1;
    if (cmd.reg_b) cnt_b <= (a == b) ? cnt_a : (known[b] ? cnt_rd : CW'(1));
    else if (cmd.wr_ab && (a == b)) cnt_b <= cnt_b + 1'b1;
    if (cmd.pop_take) begin
      cur_node <= stk_rd[FW-1:33];
      cur_prod <= stk_rd[32:1];
      cur_sat  <= stk_rd[0];
    end
    if (cmd.pop_take) idx <= '0;
    else if (cmd.idx_inc) idx <= idx + 1'b1;
    if (cmd.edge_mul) begin
      prod   <= 64'(cur_prod) * 64'(tbl_rd[31:0]);
      e_node <= tbl_rd[EW-1:32];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      known   <= '0;
      visited <= '0;
      sp      <= '0;
    end else begin
      if (cmd.reg_a && !known[a]) begin
        known[a] <= 1'b1;
        visited[a] <= 1'b0;
      end
      if (cmd.reg_b && !known[b]) begin
        known[b] <= 1'b1;
        visited[b] <= 1'b0;
      end
      if (cmd.q_init) begin
        visited <= '0;
        sp      <= SPW'(1);
      end else if (cmd.pop) begin
        sp <= sp - 1'b1;
      end else if (cmd.push) begin
        sp <= sp + 1'b1;
      end
      if (cmd.pop_take) visited[stk_rd[FW-1:33]] <= 1'b1;
    end
  end

  // restoring divider for (2^32 + r/2) / r, one quotient bit per cycle
  assign dv_trial = {dv_rem[31:0], dv_sh[32]};

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_cnt <= '0;
    end else if (cmd.div_start) begin
      dv_cnt <= 6'd33;
      dv_rem <= '0;
      dv_sh  <= {2'b10, r[31:1]};
    end else if (dv_cnt != 6'd0) begin
      dv_cnt <= dv_cnt - 1'b1;
      if (dv_trial >= {1'b0, r}) begin
        dv_rem <= dv_trial - {1'b0, r};
        dv_sh  <= {dv_sh[31:0], 1'b1};
      end else begin
        dv_rem <= dv_trial;
        dv_sh  <= {dv_sh[31:0], 1'b0};
      end
    end
  end

  assign prod_rnd = {1'b0, prod} + 65'h8000;
  assign pval     = (|prod_rnd[64:48]) ? Q_MAX : prod_rnd[47:16];
  assign psat     = cur_sat | (|prod_rnd[64:48]);

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res_ratio  <= '0;
      res_found  <= 1'b0;
      res_status <= ST_OK;
      unique case (cmd.res_sel)
        RS_ZERO: res_status <= ST_ZERO;
        RS_FULL: res_status <= ST_FULL;
        RS_ADD:  res_status <= dv_sh[32] ? ST_SAT : ST_OK;
        RS_HIT: begin
          res_ratio  <= pval;
          res_found  <= 1'b1;
          res_status <= psat ? ST_SAT : ST_OK;
        end
        RS_OVF:  res_status <= ST_SAT;
        default: res_status <= ST_OK;
      endcase
    end
  end

  assign m_tdata = {5'd0, res_status, res_found, res_ratio};

  assign cnt_a2 = {1'b0, cnt_a} + (CW + 1)'(2);

  always_comb begin
    sts.op         = op;
    sts.r_zero     = (r == 32'd0);
    sts.known_ab   = known[a] & known[b];
    sts.room       = (a == b) ? (cnt_a2 <= (CW + 1)'(MAX_DEGREE))
                              : (cnt_a < CW'(MAX_DEGREE)) && (cnt_b < CW'(MAX_DEGREE));
    sts.div_done   = (dv_cnt == 6'd0);
    sts.sp_zero    = (sp == '0);
    sts.edge_end   = (idx == cnt_rd);
    sts.hit        = (e_node == b);
    sts.e_visited  = visited[e_node];
    sts.stack_full = (sp == SPW'(STACK_DEPTH));
  end

endmodule

@@ hw/rtl/rgq_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgq_ctrl
// Sequencer for adds and depth-first queries, plus the output valid flag.
// ----------------------------------------------------------------------------
module rgq_ctrl
  import rgq_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  output logic m_tvalid,
  input  logic m_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t   state, state_next;
  res_sel_t sel, sel_next;
  logic     out_valid, out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      sel       <= RS_NONE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      sel       <= sel_next;
      out_valid <= out_valid_next;
    end
  end

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = out_valid;

  always_comb begin
    state_next     = state;
    sel_next       = sel;
    out_valid_next = out_valid && !m_tready;
    cmd            = '0;
    cmd.res_sel    = sel;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.op == OP_ADD) begin
          if (sts.r_zero) begin
            sel_next   = RS_ZERO;
            state_next = S_DONE;
          end else begin
            state_next = S_REG_A;
          end
        end else if (sts.known_ab) begin
          state_next = S_Q_INIT;
        end else begin
          sel_next   = RS_NONE;
          state_next = S_DONE;
        end
      end
      S_REG_A: begin
        cmd.reg_a  = 1'b1;
        state_next = S_REG_B;
      end
      S_REG_B: begin
        cmd.reg_b  = 1'b1;
        state_next = S_ROOM;
      end
      S_ROOM: begin
        if (sts.room) begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end else begin
          sel_next   = RS_FULL;
          state_next = S_DONE;
        end
      end
      S_DIV: begin
        if (sts.div_done) state_next = S_WR_AB;
      end
      S_WR_AB: begin
        cmd.wr_ab  = 1'b1;
        state_next = S_WR_BA;
      end
      S_WR_BA: begin
        cmd.wr_ba  = 1'b1;
        sel_next   = RS_ADD;
        state_next = S_DONE;
      end
      S_Q_INIT: begin
        cmd.q_init = 1'b1;
        state_next = S_POP;
      end
      S_POP: begin
        if (sts.sp_zero) begin
          sel_next   = RS_NONE;
          state_next = S_DONE;
        end else begin
          cmd.pop    = 1'b1;
          state_next = S_POP_TAKE;
        end
      end
      S_POP_TAKE: begin
        cmd.pop_take = 1'b1;
        state_next   = S_EDGE_RD;
      end
      S_EDGE_RD: begin
        state_next = sts.edge_end ? S_POP : S_EDGE_WAIT;
      end
      S_EDGE_WAIT: begin
        cmd.edge_mul = 1'b1;
        state_next   = S_EVAL;
      end
      S_EVAL: begin
        if (sts.hit) begin
          sel_next   = RS_HIT;
          state_next = S_DONE;
        end else if (!sts.e_visited && sts.stack_full) begin
          sel_next   = RS_OVF;
          state_next = S_DONE;
        end else begin
          cmd.push    = !sts.e_visited;
          cmd.idx_inc = 1'b1;
          state_next  = S_EDGE_RD;
        end
      end
      S_DONE: begin
        // hold until the output register is free
        if (!out_valid || m_tready) begin
          cmd.res_load   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
